>>> sv/lbbt_pkg.sv
package lbbt_pkg;

  localparam int SLOTS         = 64;
  localparam int AGE_BITS      = 16;
  localparam int BLOCK_BITS    = 32;
  localparam int OUT_SLOT_BITS = 6;
  localparam int SLOT_BITS     = $clog2(SLOTS);
  localparam int CNT_BITS      = $clog2(SLOTS + 1);

  typedef logic [SLOT_BITS-1:0]     slot_idx_t;
  typedef logic [CNT_BITS-1:0]      cnt_t;
  typedef logic [AGE_BITS-1:0]      age_t;
  typedef logic [OUT_SLOT_BITS-1:0] slot_out_t;

  localparam age_t AGE_ZERO = '0;
  localparam age_t AGE_ONE  = age_t'(1);
  localparam age_t AGE_MAX  = '1;

  typedef struct packed {
    logic [BLOCK_BITS-1:0] blk;
    logic                  spc;
  } key_t;

  // sequencer -> tag and age stores
  typedef struct packed {
    logic      clr;         // new request accepted
    logic      rd_en;       // scan read issued
    slot_idx_t rd_addr;
    logic      chk_v;       // read data of chk_idx valid this cycle
    slot_idx_t chk_idx;
    logic      fix_en;      // final write of the chosen slot
    logic      fix_tag_we;  // new key goes into the chosen slot
    slot_idx_t fix_addr;
    age_t      fix_age;
  } scan_ctl_t;

  // tag store -> sequencer
  typedef struct packed {
    logic      found;
    slot_idx_t found_idx;
    key_t      best_key;
  } tag_res_t;

  function automatic age_t age_inc(age_t a);
    age_t r;
    r = (a == AGE_MAX) ? a : a + AGE_ONE;
    return r;
  endfunction

endpackage

>>> sv/lbbt_tag_scan.sv
module lbbt_tag_scan (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [lbbt_pkg::BLOCK_BITS-1:0]     block_number,
  input  logic                                block_space,
  input  lbbt_pkg::scan_ctl_t                 ctl,
  input  logic                                new_best,
  output lbbt_pkg::tag_res_t                  res
);

  lbbt_pkg::key_t    mem [lbbt_pkg::SLOTS];
  lbbt_pkg::key_t    rd_key;
  lbbt_pkg::key_t    key;
  logic              found;
  lbbt_pkg::slot_idx_t found_idx;
  lbbt_pkg::key_t    best_key;

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_key <= mem[ctl.rd_addr];
    end
    if (ctl.fix_tag_we) begin
      mem[ctl.fix_addr] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      key.blk <= block_number;
      key.spc <= block_space;
    end
    if (ctl.chk_v && new_best) begin
      best_key <= rd_key;
    end
    if (ctl.chk_v && !found && rd_key == key) begin
      found_idx <= ctl.chk_idx;
    end
  end

  // first match wins
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clr) begin
      found <= 1'b0;
    end else if (ctl.chk_v && rd_key == key) begin
      found <= 1'b1;
    end
  end

  assign res.found     = found;
  assign res.found_idx = found_idx;
  assign res.best_key  = best_key;

endmodule

>>> sv/lbbt_age_scan.sv
module lbbt_age_scan (
  input  logic                clk,
  input  lbbt_pkg::scan_ctl_t ctl,
  output logic                new_best,
  output lbbt_pkg::slot_idx_t best_idx
);

  lbbt_pkg::age_t mem [lbbt_pkg::SLOTS];
  lbbt_pkg::age_t rd_age;
  lbbt_pkg::age_t best_age;

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_age <= mem[ctl.rd_addr];
    end
    // scan write-back trails the read by one slot, so addresses never collide
    if (ctl.chk_v) begin
      mem[ctl.chk_idx] <= lbbt_pkg::age_inc(rd_age);
    end else if (ctl.fix_en) begin
      mem[ctl.fix_addr] <= ctl.fix_age;
    end
  end

  // strict compare keeps the lowest slot on ties
  assign new_best = ctl.chk_v && (ctl.chk_idx == '0 || rd_age > best_age);

  always_ff @(posedge clk) begin
    if (new_best) begin
      best_age <= rd_age;
      best_idx <= ctl.chk_idx;
    end
  end

endmodule

>>> sv/lbbt_ctrl.sv
module lbbt_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  output logic                                done,
  input  lbbt_pkg::tag_res_t                  tres,
  input  lbbt_pkg::slot_idx_t                 best_idx,
  output lbbt_pkg::scan_ctl_t                 ctl,
  output logic [lbbt_pkg::OUT_SLOT_BITS-1:0]  slot,
  output logic                                hit,
  output logic                                evicted,
  output logic [lbbt_pkg::BLOCK_BITS-1:0]     evicted_block,
  output logic                                evicted_space
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;

  logic [1:0]          state;
  lbbt_pkg::cnt_t      fill_count;
  lbbt_pkg::cnt_t      n;
  lbbt_pkg::cnt_t      rd_idx;
  logic                chk_v;
  lbbt_pkg::slot_idx_t chk_idx;
  logic                accept;
  logic                issue;
  logic                full;
  lbbt_pkg::slot_idx_t fix_slot;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);
  assign issue  = (state == ST_SCAN) && (rd_idx < n);
  assign full   = (n == lbbt_pkg::cnt_t'(lbbt_pkg::SLOTS));

  always_comb begin
    priority if (tres.found) begin
      fix_slot = tres.found_idx;
    end else if (!full) begin
      fix_slot = n[lbbt_pkg::SLOT_BITS-1:0];
    end else begin
      fix_slot = best_idx;
    end
  end

  always_comb begin
    ctl.clr        = accept;
    ctl.rd_en      = issue;
    ctl.rd_addr    = rd_idx[lbbt_pkg::SLOT_BITS-1:0];
    ctl.chk_v      = chk_v;
    ctl.chk_idx    = chk_idx;
    ctl.fix_en     = (state == ST_FIX);
    ctl.fix_tag_we = (state == ST_FIX) && !tres.found;
    ctl.fix_addr   = fix_slot;
    // a fresh fill starts at age 0, hit and replace at 1
    ctl.fix_age    = (!tres.found && !full) ? lbbt_pkg::AGE_ZERO : lbbt_pkg::AGE_ONE;
  end

  always_ff @(posedge clk) begin
    chk_idx <= rd_idx[lbbt_pkg::SLOT_BITS-1:0];
    if (state == ST_FIX) begin
      slot          <= lbbt_pkg::slot_out_t'(fix_slot);
      hit           <= tres.found;
      evicted       <= !tres.found && full;
      evicted_block <= (!tres.found && full) ? tres.best_key.blk : '0;
      evicted_space <= !tres.found && full && tres.best_key.spc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      done       <= 1'b0;
      chk_v      <= 1'b0;
      n          <= '0;
      rd_idx     <= '0;
    end else begin
      done  <= 1'b0;
      chk_v <= issue;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            n      <= fill_count;
            rd_idx <= '0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            rd_idx <= rd_idx + lbbt_pkg::cnt_t'(1);
          end else if (!chk_v) begin
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          if (!tres.found && !full) begin
            fill_count <= n + lbbt_pkg::cnt_t'(1);
          end
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_after_fix: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FIX))
    else $error("result strobe without final write");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted request did not raise busy");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= lbbt_pkg::cnt_t'(lbbt_pkg::SLOTS))
    else $error("fill count beyond slot count");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> (rd_idx < n && n <= lbbt_pkg::cnt_t'(lbbt_pkg::SLOTS)))
    else $error("scan read past filled slots");
`endif

endmodule

>>> sv/lru_block_buffer_tags.sv
// Fully associative tag store with LRU replacement by per-slot age counters.
// A request (block_number, block_space) is taken at a clock edge where start
// is high and busy is low. The block then walks every filled slot once, one
// slot per cycle through the tag and age memories: tags are compared for a
// hit, the oldest slot is tracked, and each age is written back incremented
// (saturating) in the cycle after its read. A final step writes the chosen
// slot: age 1 on a hit or replacement, age 0 with the new tag on a fill of a
// free slot. The result shows for exactly one cycle with done high, the same
// cycle busy drops; the receiver must take it then, it cannot be held off.
// evicted_block and evicted_space are zero unless evicted is set. No clearing
// pass after reset: only slots below the fill count are ever read.
module lru_block_buffer_tags (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [lbbt_pkg::BLOCK_BITS-1:0]     block_number,
  input  logic                                block_space,
  output logic                                done,
  output logic [lbbt_pkg::OUT_SLOT_BITS-1:0]  slot,
  output logic                                hit,
  output logic                                evicted,
  output logic [lbbt_pkg::BLOCK_BITS-1:0]     evicted_block,
  output logic                                evicted_space
);

  lbbt_pkg::scan_ctl_t ctl;    // sequencer commands to both memories
  lbbt_pkg::tag_res_t  tres;   // match and oldest-key tracking
  lbbt_pkg::slot_idx_t best_idx;
  logic                new_best;

  // tag memory, compare and capture of the oldest slot's key
  lbbt_tag_scan u_tag (
    .clk          (clk),
    .rst          (rst),
    .block_number (block_number),
    .block_space  (block_space),
    .ctl          (ctl),
    .new_best     (new_best),
    .res          (tres)
  );

  // age memory, saturating read-modify-write and oldest-slot search
  lbbt_age_scan u_age (
    .clk      (clk),
    .ctl      (ctl),
    .new_best (new_best),
    .best_idx (best_idx)
  );

  // request sequencer, fill count and result register
  lbbt_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .tres          (tres),
    .best_idx      (best_idx),
    .ctl           (ctl),
    .slot          (slot),
    .hit           (hit),
    .evicted       (evicted),
    .evicted_block (evicted_block),
    .evicted_space (evicted_space)
  );

endmodule
